FILE: rtl/core/xcfp_pkg.sv
// ---------------------------------------------------------------------------
// xcfp_pkg: shared types and constants of the XOR-checked frame parser
// Frame phases, result status codes and payload store sizing.
// ---------------------------------------------------------------------------
package xcfp_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

  localparam logic [7:0] MAX_LEN_BYTE   = 8'(MAX_PAYLOAD);
  localparam logic [7:0] HEADER_DEFAULT = 8'h9a;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_CHECK,
    PH_DRAIN
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_MISMATCH   = 2'd1,
    ST_TOO_LONG   = 2'd2,
    ST_INCOMPLETE = 2'd3
  } status_t;

endpackage

FILE: rtl/core/xor_checked_frame_parser_top.sv
// ---------------------------------------------------------------------------
// xor_checked_frame_parser_top: byte-stream deframer with XOR check
// Hunts for the header byte, collects command and length in registers and
// payload in a RAM, checks XOR, replays good frames as results or reports errors.
// ---------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready, rx_byte, flush): one stream byte per
//   transfer. in_ready is high whenever the parser is not replaying a frame
//   and the output register is free or being emptied in the same cycle.
//   Output channel (out_valid/out_ready plus the six result fields): a
//   single output register; a result caused by an input byte is visible the
//   cycle after that byte's transfer.
//   Config channel (cfg_valid/cfg_ready, header_value): always ready; write
//   only while the parser is idle. Takes effect at the next header hunt.
// Throughput
//   One byte per cycle while no results are pending. After a good check
//   byte with length N > 0 the parser stops taking input and drains the
//   payload RAM: the first result follows the phase change and the first
//   registered RAM read, then one result per cycle while the output register
//   is free, set by the RAM's single synchronous read port.
// Reset and stalls
//   rst (synchronous) returns to header hunt, restores header 0x9a and
//   empties the output register; the payload RAM is not cleared. A held
//   result blocks input and the drain until the output register frees up.
// ---------------------------------------------------------------------------
module xor_checked_frame_parser_top (
  input  logic       clk,
  input  logic       rst,
  // config write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] header_value,
  // byte input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       flush,
  // result output channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] command_code,
  output logic [7:0] frame_length,
  output logic [7:0] payload_byte,
  output logic       byte_valid,
  output logic       last_of_frame,
  output logic [1:0] frame_status
);

  // -------------------------------------------------------------------------
  // State
  // -------------------------------------------------------------------------
  xcfp_pkg::phase_t phase, phase_next;

  logic [7:0]                  header_reg;
  logic [7:0]                  running_xor;
  logic [7:0]                  held_command;
  logic [7:0]                  held_length;
  logic [xcfp_pkg::CNT_W-1:0]  bytes_taken;
  logic [xcfp_pkg::ADDR_W-1:0] emit_idx;     // RAM entry held in rd_data
  logic                        rd_pend;      // rd_data is valid for emit_idx

  // payload RAM, one write and one registered read per cycle
  logic [7:0] payload_store [xcfp_pkg::MAX_PAYLOAD];
  logic [7:0] rd_data;
  logic [xcfp_pkg::ADDR_W-1:0] rd_addr;
  logic                        mem_we;

  // -------------------------------------------------------------------------
  // Handshakes
  // -------------------------------------------------------------------------
  logic slot_free;
  logic in_fire;
  logic drain_emit;
  logic drain_last;
  logic [xcfp_pkg::CNT_W-1:0] taken_inc;
  logic xor_ok;

  assign cfg_ready  = 1'b1;
  assign slot_free  = !out_valid || out_ready;
  assign in_ready   = (phase != xcfp_pkg::PH_DRAIN) && slot_free;
  assign in_fire    = in_valid && in_ready;
  assign drain_emit = (phase == xcfp_pkg::PH_DRAIN) && rd_pend && slot_free;
  assign drain_last = (8'(emit_idx) + 8'd1) == held_length;
  assign taken_inc  = bytes_taken + xcfp_pkg::CNT_W'(1);
  assign xor_ok     = rx_byte == running_xor;

  // next read address: advance once the current entry leaves
  assign rd_addr = drain_emit ? xcfp_pkg::ADDR_W'(emit_idx + 1'b1) : emit_idx;

  // -------------------------------------------------------------------------
  // Next phase
  // -------------------------------------------------------------------------
  always_comb begin
    phase_next = phase;
    case (phase)
      xcfp_pkg::PH_HUNT: begin
        if (in_fire && rx_byte == header_reg) begin
          phase_next = flush ? xcfp_pkg::PH_HUNT : xcfp_pkg::PH_CMD;
        end
      end
      xcfp_pkg::PH_CMD: begin
        if (in_fire) begin
          phase_next = flush ? xcfp_pkg::PH_HUNT : xcfp_pkg::PH_LEN;
        end
      end
      xcfp_pkg::PH_LEN: begin
        if (in_fire) begin
          if (rx_byte > xcfp_pkg::MAX_LEN_BYTE || flush) begin
            phase_next = xcfp_pkg::PH_HUNT;
          end else if (rx_byte == 8'd0) begin
            phase_next = xcfp_pkg::PH_CHECK;
          end else begin
            phase_next = xcfp_pkg::PH_DATA;
          end
        end
      end
      xcfp_pkg::PH_DATA: begin
        if (in_fire) begin
          if (flush) begin
            phase_next = xcfp_pkg::PH_HUNT;
          end else if (8'(taken_inc) >= held_length) begin
            phase_next = xcfp_pkg::PH_CHECK;
          end
        end
      end
      xcfp_pkg::PH_CHECK: begin
        if (in_fire) begin
          phase_next = (xor_ok && held_length != 8'd0) ? xcfp_pkg::PH_DRAIN
                                                       : xcfp_pkg::PH_HUNT;
        end
      end
      xcfp_pkg::PH_DRAIN: begin
        if (drain_emit && drain_last) begin
          phase_next = xcfp_pkg::PH_HUNT;
        end
      end
      default: phase_next = xcfp_pkg::PH_HUNT;
    endcase
  end

  // -------------------------------------------------------------------------
  // Result selection and RAM write
  // -------------------------------------------------------------------------
  logic                res_load;
  logic [7:0]          res_cmd;
  logic [7:0]          res_len;
  logic [7:0]          res_data;
  logic                res_valid;
  logic                res_last;
  xcfp_pkg::status_t   res_status;

  always_comb begin
    res_load   = 1'b0;
    res_cmd    = 8'd0;
    res_len    = held_length;
    res_data   = 8'd0;
    res_valid  = 1'b0;
    res_last   = 1'b1;
    res_status = xcfp_pkg::ST_OK;
    mem_we     = 1'b0;
    case (phase)
      xcfp_pkg::PH_HUNT: begin
        // header carrying flush: incomplete, length not yet seen
        if (in_fire && rx_byte == header_reg && flush) begin
          res_load   = 1'b1;
          res_len    = 8'd0;
          res_status = xcfp_pkg::ST_INCOMPLETE;
        end
      end
      xcfp_pkg::PH_CMD: begin
        if (in_fire && flush) begin
          res_load   = 1'b1;
          res_status = xcfp_pkg::ST_INCOMPLETE;
        end
      end
      xcfp_pkg::PH_LEN: begin
        res_len = rx_byte;
        if (in_fire) begin
          if (rx_byte > xcfp_pkg::MAX_LEN_BYTE) begin
            res_load   = 1'b1;
            res_status = xcfp_pkg::ST_TOO_LONG;
          end else if (flush) begin
            res_load   = 1'b1;
            res_status = xcfp_pkg::ST_INCOMPLETE;
          end
        end
      end
      xcfp_pkg::PH_DATA: begin
        mem_we = in_fire;
        if (in_fire && flush) begin
          res_load   = 1'b1;
          res_status = xcfp_pkg::ST_INCOMPLETE;
        end
      end
      xcfp_pkg::PH_CHECK: begin
        if (in_fire) begin
          if (!xor_ok) begin
            res_load   = 1'b1;
            res_status = xcfp_pkg::ST_MISMATCH;
          end else if (held_length == 8'd0) begin
            res_load = 1'b1;
            res_cmd  = held_command;
          end
        end
      end
      xcfp_pkg::PH_DRAIN: begin
        res_load  = drain_emit;
        res_cmd   = held_command;
        res_data  = rd_data;
        res_valid = 1'b1;
        res_last  = drain_last;
      end
      default: ;
    endcase
  end

  // -------------------------------------------------------------------------
  // Payload RAM
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      payload_store[bytes_taken[xcfp_pkg::ADDR_W-1:0]] <= rx_byte;
    end
    rd_data <= payload_store[rd_addr];
  end

  // -------------------------------------------------------------------------
  // Control and frame registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= xcfp_pkg::PH_HUNT;
      header_reg   <= xcfp_pkg::HEADER_DEFAULT;
      running_xor  <= 8'd0;
      held_command <= 8'd0;
      held_length  <= 8'd0;
      bytes_taken  <= '0;
      emit_idx     <= '0;
      rd_pend      <= 1'b0;
    end else begin
      phase <= phase_next;
      if (cfg_valid && cfg_ready) begin
        header_reg <= header_value;
      end
      if (in_fire) begin
        case (phase)
          xcfp_pkg::PH_HUNT: begin
            if (rx_byte == header_reg) begin
              running_xor  <= rx_byte;
              held_command <= 8'd0;
              held_length  <= 8'd0;
              bytes_taken  <= '0;
            end
          end
          xcfp_pkg::PH_CMD: begin
            running_xor  <= running_xor ^ rx_byte;
            held_command <= rx_byte;
          end
          xcfp_pkg::PH_LEN: begin
            running_xor <= running_xor ^ rx_byte;
            held_length <= rx_byte;
            bytes_taken <= '0;
          end
          xcfp_pkg::PH_DATA: begin
            running_xor <= running_xor ^ rx_byte;
            bytes_taken <= taken_inc;
          end
          default: ;
        endcase
      end
      // drain pointer: start at entry 0, read data valid from the cycle after the drain starts
      if (phase != xcfp_pkg::PH_DRAIN) begin
        emit_idx <= '0;
        rd_pend  <= 1'b0;
      end else begin
        emit_idx <= rd_addr;
        rd_pend  <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Output register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      command_code  <= res_cmd;
      frame_length  <= res_len;
      payload_byte  <= res_data;
      byte_valid    <= res_valid;
      last_of_frame <= res_last;
      frame_status  <= res_status;
    end
  end

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!out_valid || out_ready))
    else $error("result loaded over a pending one");

  // drain only runs on a stored, in-range frame
  a_drain_len: assert property (@(posedge clk) disable iff (rst)
    (phase == xcfp_pkg::PH_DRAIN) |->
      (held_length != 8'd0 && held_length <= xcfp_pkg::MAX_LEN_BYTE))
    else $error("drain with bad length");

  // payload writes stay inside the announced length
  a_write_bound: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (8'(bytes_taken) < held_length))
    else $error("payload write past frame length");

  // data-carrying results are always good-frame results
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    (res_load && res_valid) |=> (frame_status == xcfp_pkg::ST_OK && byte_valid))
    else $error("payload result with error status");
`endif

endmodule
